### sv/ssq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// full-step stepper sequencer. No dependencies.
package ssq_pkg;

    localparam int PHASE_COUNT = 4;
    localparam int PHASE_W     = $clog2(PHASE_COUNT);

    localparam int DATA_W    = 32;
    localparam int PSC_W     = 16;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 8;
    localparam int COIL_W    = 4;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    localparam logic [REQ_W-1:0] REQ_DRIVE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER   = 8'd1;

    localparam logic [DATA_W-1:0] TIMER_CLOCK_RESET = 32'd16000000;

    localparam logic [COIL_W-1:0] STEP_PATTERNS [8] = '{
        4'hC, 4'h6, 4'h3, 4'h9, 4'hC, 4'h6, 4'h3, 4'h9
    };

    typedef struct packed {
        logic take_simple;   // finish a simple item now (tick, stop, unused code or rejected drive)
        logic load_drive;    // latch an accepted drive command
        logic div_start;     // launch the shared divider
        logic div_second;    // divider operands: quotient / step rate
        logic drive_done;    // commit the drive command
    } t_dp_cmd;

    typedef struct packed {
        logic drive_ok;      // offered item is a drive with nonzero count and rate
        logic div_done;
        logic out_blocked;   // output register holds a result that is stalled
    } t_dp_status;

endpackage

### sv/ssq_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssq_pkg.
module ssq_div
    import ssq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DATA_W-1:0]    r_quo, n_quo;
    logic [DATA_W-1:0]    r_dvs, n_dvs;
    logic [DATA_W:0]      w_shift;
    logic [DATA_W:0]      w_diff;

    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                n_rem = w_diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### sv/ssq_dp.sv
// Datapath: configuration registers, motion state, tick counters, phase
// sequencing, divider operand selection and the output register.
// Depends on ssq_pkg and ssq_div.
module ssq_dp
    import ssq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic signed [31:0]   i_step_count,
    input  logic [31:0]          i_step_rate_hz,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [COIL_W-1:0]    o_coil_pattern,
    output logic                 o_coils_changed,
    output logic                 o_status_bit,
    output logic                 o_running,
    output logic [DATA_W-1:0]    o_steps_left
);

    logic [DATA_W-1:0]  r_timer_clk;
    logic [PSC_W-1:0]   r_prescaler;
    logic [DATA_W-1:0]  r_count;
    logic [DATA_W-1:0]  r_rate;

    logic [DATA_W-1:0]  r_remaining, n_remaining;
    logic               r_backward, n_backward;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_active, n_active;
    logic [DATA_W-1:0]  r_reload, n_reload;
    logic [PSC_W-1:0]   r_psc_cnt, n_psc_cnt;
    logic [DATA_W-1:0]  r_period, n_period;
    logic [COIL_W-1:0]  r_coil, n_coil;

    logic               r_out_valid, n_out_valid;
    logic [COIL_W-1:0]  r_out_coil;
    logic               r_out_changed;
    logic               r_out_rejected;
    logic               r_out_running;
    logic [DATA_W-1:0]  r_out_steps;

    logic               w_changed;
    logic               w_rejected;
    logic [PHASE_W-1:0] w_phase;
    logic               w_write_out;
    logic [DATA_W-1:0]  w_div_dividend;
    logic [DATA_W-1:0]  w_div_divisor;
    logic               w_div_done;
    logic [DATA_W-1:0]  w_quotient;

    // first pass: clock / (prescaler + 1); second pass: that / rate
    assign w_div_dividend = i_cmd.div_second ? w_quotient : r_timer_clk;
    assign w_div_divisor  = i_cmd.div_second ? r_rate
                                             : DATA_W'({1'b0, r_prescaler} + 17'd1);

    ssq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_status.drive_ok    = (i_req_type == REQ_DRIVE) && (i_step_count != '0)
                                  && (i_step_rate_hz != '0);
    assign o_status.div_done    = w_div_done;
    assign o_status.out_blocked = r_out_valid && i_out_stall;

    assign w_phase = (32'(r_phase) >= PHASE_COUNT) ? '0 : r_phase;

    always_comb begin
        n_remaining = r_remaining;
        n_backward  = r_backward;
        n_phase     = r_phase;
        n_active    = r_active;
        n_reload    = r_reload;
        n_psc_cnt   = r_psc_cnt;
        n_period    = r_period;
        n_coil      = r_coil;
        w_changed   = 1'b0;
        w_rejected  = 1'b0;
        if (i_cmd.take_simple) begin
            case (i_req_type)
                REQ_DRIVE: begin
                    w_rejected = 1'b1;
                end
                REQ_STOP: begin
                    n_remaining = '0;
                    n_active    = 1'b0;
                end
                REQ_TICK: begin
                    if (r_active) begin
                        if (r_psc_cnt >= r_prescaler) begin
                            n_psc_cnt = '0;
                            if (r_period >= r_reload) begin
                                n_period = '0;
                                // step event: stop when nothing is left
                                if (r_remaining == '0) begin
                                    n_active = 1'b0;
                                end else begin
                                    n_coil = STEP_PATTERNS[3'(w_phase)];
                                    if (r_backward) begin
                                        n_phase = (w_phase == '0)
                                                  ? PHASE_W'(PHASE_COUNT - 1)
                                                  : w_phase - 1'b1;
                                    end else begin
                                        n_phase = (w_phase == PHASE_W'(PHASE_COUNT - 1))
                                                  ? '0 : w_phase + 1'b1;
                                    end
                                    n_remaining = r_remaining - 1'b1;
                                    w_changed   = 1'b1;
                                end
                            end else begin
                                n_period = r_period + 1'b1;
                            end
                        end else begin
                            n_psc_cnt = r_psc_cnt + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.drive_done) begin
            n_backward  = r_count[DATA_W-1];
            n_remaining = r_count[DATA_W-1] ? DATA_W'(0) - r_count : r_count;
            n_reload    = (w_quotient == '0) ? '0 : w_quotient - 1'b1;
            n_psc_cnt   = '0;
            n_period    = '0;
            n_active    = 1'b1;
        end
    end

    assign w_write_out = i_cmd.take_simple || i_cmd.drive_done;
    assign n_out_valid = w_write_out ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_clk <= TIMER_CLOCK_RESET;
            r_prescaler <= '0;
            r_remaining <= '0;
            r_backward  <= 1'b0;
            r_phase     <= '0;
            r_active    <= 1'b0;
            r_reload    <= '0;
            r_psc_cnt   <= '0;
            r_period    <= '0;
            r_coil      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIMER_CLOCK: r_timer_clk <= i_cfg_data;
                    CFG_PRESCALER:   r_prescaler <= i_cfg_data[PSC_W-1:0];
                    default: ;
                endcase
            end
            r_remaining <= n_remaining;
            r_backward  <= n_backward;
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_reload    <= n_reload;
            r_psc_cnt   <= n_psc_cnt;
            r_period    <= n_period;
            r_coil      <= n_coil;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_drive) begin
            r_count <= DATA_W'(i_step_count);
            r_rate  <= i_step_rate_hz;
        end
        if (w_write_out) begin
            r_out_coil     <= n_coil;
            r_out_changed  <= w_changed;
            r_out_rejected <= w_rejected;
            r_out_running  <= n_active;
            r_out_steps    <= n_remaining;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_coil_pattern  = r_out_coil;
    assign o_coils_changed = r_out_changed;
    assign o_status_bit    = r_out_rejected;
    assign o_running       = r_out_running;
    assign o_steps_left    = r_out_steps;

endmodule

### sv/ssq_ctrl.sv
// Controller: input handshake and sequencing of the two divider passes of
// a drive command. Depends on ssq_pkg.
module ssq_ctrl
    import ssq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV1 = 2'd1;
    localparam logic [1:0] ST_DIV2 = 2'd2;

    logic [1:0] r_state, n_state;
    logic       w_take;

    assign o_in_stall = (r_state != ST_IDLE) || i_status.out_blocked;
    assign w_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_status.drive_ok) begin
                        o_cmd.load_drive = 1'b1;
                        o_cmd.div_start  = 1'b1;
                        n_state          = ST_DIV1;
                    end else begin
                        o_cmd.take_simple = 1'b1;
                    end
                end
            end
            ST_DIV1: begin
                if (i_status.div_done) begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_second = 1'b1;
                    n_state          = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (i_status.div_done) begin
                    o_cmd.drive_done = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/stepper_full_step_sequencer.sv
// Two-phase full-step stepper sequencer, top level.
// Tick, stop, unused-code and rejected drive items: result registered on the accept edge.
// Accepted drive: the input is held while the shared bit-serial divider runs two passes, the
// second launched when the first is done; the commit then registers the result and frees the input.
// One item in flight; a stalled result in the output register holds the input.
// Reset (synchronous, active low): motion state cleared, clock 16 MHz, prescaler 0.
module stepper_full_step_sequencer
    import ssq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic signed [31:0]   i_step_count,
    input  logic [31:0]          i_step_rate_hz,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [COIL_W-1:0]    o_coil_pattern,
    output logic                 o_coils_changed,
    output logic                 o_status,
    output logic                 o_running,
    output logic [DATA_W-1:0]    o_steps_left,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ssq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ssq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_step_count    (i_step_count),
        .i_step_rate_hz  (i_step_rate_hz),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_coil_pattern  (o_coil_pattern),
        .o_coils_changed (o_coils_changed),
        .o_status_bit    (o_status),
        .o_running       (o_running),
        .o_steps_left    (o_steps_left)
    );

    // a committed drive must show up in the output register
    a_drive_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drive_done |=> o_out_valid)
        else $error("drive commit did not produce a result");

    // hold the input while the divider works
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_drive |=> o_in_stall)
        else $error("input open during drive computation");

    // a step only happens while running
    a_step_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_coils_changed) |-> o_running)
        else $error("coil change reported while stopped");

    // a rejected drive never steps
    a_reject_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> !o_coils_changed)
        else $error("rejected drive reported a step");

endmodule

### tb/stepper_full_step_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_full_step_sequencer: directed and random drive, stop, tick
// and unused-code transfers and register writes, checked field by field against a sequencer model
// kept in this bench. Depends on ssq_pkg and the sequencer RTL.
module stepper_full_step_sequencer_test;
    import ssq_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;
    localparam logic [COIL_W-1:0]    FULL_STEP_SEQ [PHASE_COUNT] = '{4'hC, 4'h6, 4'h3, 4'h9};

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              changed;
        logic              status;
        logic              running;
        logic [DATA_W-1:0] steps_left;
    } t_coil_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic signed [31:0]   i_step_count;
    logic [31:0]          i_step_rate_hz;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [COIL_W-1:0]    o_coil_pattern;
    logic                 o_coils_changed;
    logic                 o_status;
    logic                 o_running;
    logic [DATA_W-1:0]    o_steps_left;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    // sequencer model state and its copy of the registers
    logic [31:0]       seq_clock_hz;
    logic [PSC_W-1:0]  seq_prescaler;
    logic [31:0]       seq_remaining;
    logic              seq_backward;
    int                seq_phase;
    logic              seq_active;
    logic [31:0]       seq_reload;
    logic [PSC_W-1:0]  seq_prescale_cnt;
    logic [31:0]       seq_period_cnt;
    logic [COIL_W-1:0] seq_coils;

    t_coil_result expected_coil_states [$];
    int           mismatch_count = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_left = 0;

    stepper_full_step_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_step_count    (i_step_count),
        .i_step_rate_hz  (i_step_rate_hz),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_coil_pattern  (o_coil_pattern),
        .o_coils_changed (o_coils_changed),
        .o_status        (o_status),
        .o_running       (o_running),
        .o_steps_left    (o_steps_left),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Apply one request to the model and return the state the block should report.
    function automatic t_coil_result advance_sequencer(input logic [REQ_W-1:0] req,
                                                       input logic [31:0] count,
                                                       input logic [31:0] rate);
        t_coil_result res;
        logic [31:0]  tick_rate;
        logic [31:0]  quot;
        res.changed = 1'b0;
        res.status  = 1'b0;
        if (req == REQ_DRIVE) begin
            if (count == 32'd0 || rate == 32'd0) begin
                res.status = 1'b1;
            end else begin
                seq_backward     = count[31];
                seq_remaining    = count[31] ? (32'd0 - count) : count;
                tick_rate        = seq_clock_hz / ({16'd0, seq_prescaler} + 32'd1);
                quot             = tick_rate / rate;
                seq_reload       = (quot == 32'd0) ? 32'd0 : quot - 32'd1;
                seq_prescale_cnt = '0;
                seq_period_cnt   = '0;
                seq_active       = 1'b1;
            end
        end else if (req == REQ_STOP) begin
            seq_remaining = '0;
            seq_active    = 1'b0;
        end else if (req == REQ_TICK && seq_active) begin
            // both counters wrap on reached-or-passed
            if (seq_prescale_cnt >= seq_prescaler) begin
                seq_prescale_cnt = '0;
                if (seq_period_cnt >= seq_reload) begin
                    seq_period_cnt = '0;
                    if (seq_remaining == 32'd0) begin
                        seq_active = 1'b0;
                    end else begin
                        seq_coils = FULL_STEP_SEQ[seq_phase];
                        if (seq_backward)
                            seq_phase = (seq_phase == 0) ? PHASE_COUNT - 1 : seq_phase - 1;
                        else
                            seq_phase = (seq_phase == PHASE_COUNT - 1) ? 0 : seq_phase + 1;
                        seq_remaining = seq_remaining - 32'd1;
                        res.changed   = 1'b1;
                    end
                end else begin
                    seq_period_cnt = seq_period_cnt + 32'd1;
                end
            end else begin
                seq_prescale_cnt = seq_prescale_cnt + 1'b1;
            end
        end
        res.coils      = seq_coils;
        res.running    = seq_active;
        res.steps_left = seq_remaining;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one request; returns at the edge that takes the transfer.
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [31:0] count,
                             input logic [31:0] rate);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_step_count   <= count;
        i_step_rate_hz <= rate;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_coil_states.push_back(advance_sequencer(req, count, rate));
    endtask

    // Write a register once every outstanding result has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_coil_states.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TIMER_CLOCK)
            seq_clock_hz = data;
        else if (idx == CFG_PRESCALER)
            seq_prescaler = data[PSC_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: a counted hold-off when requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_coil_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_coil_states.size() == 0) begin
                report_mismatch("result with nothing pending", o_steps_left, 32'd0);
            end else begin
                want = expected_coil_states.pop_front();
                if (o_coil_pattern !== want.coils)
                    report_mismatch("coil_pattern", 32'(o_coil_pattern), 32'(want.coils));
                if (o_coils_changed !== want.changed)
                    report_mismatch("coils_changed", 32'(o_coils_changed),
                                    32'(want.changed));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_running !== want.running)
                    report_mismatch("running", 32'(o_running), 32'(want.running));
                if (o_steps_left !== want.steps_left)
                    report_mismatch("steps_left", o_steps_left, want.steps_left);
            end
        end
    end

    task automatic test_idle_requests();
        send_item(REQ_TICK, 32'd0, 32'd0);
        send_item(REQ_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(REQ_UNUSED, 32'd7, 32'd7);
        send_item(REQ_DRIVE, 32'd0, 32'd100);
        send_item(REQ_DRIVE, 32'd5, 32'd0);
        send_item(REQ_DRIVE, 32'd0, 32'd0);
    endtask

    // One step per tick; the tick after the last step stops the run.
    task automatic test_forward_run();
        send_item(REQ_DRIVE, 32'd5, 32'd16_000_000);
        repeat (6) send_item(REQ_TICK, 32'd0, 32'd0);
    endtask

    task automatic test_backward_run();
        send_item(REQ_DRIVE, -32'sd3, 32'hFFFF_FFFF);
        repeat (4) send_item(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_extreme_counts();
        send_item(REQ_DRIVE, 32'h8000_0000, 32'd4_000_000);
        repeat (4) send_item(REQ_TICK, 32'd0, 32'd0);
        send_item(REQ_DRIVE, 32'h7FFF_FFFF, 32'd1);
        send_item(REQ_TICK, 32'd0, 32'd0);
        send_item(REQ_STOP, 32'd0, 32'd0);
    endtask

    task automatic test_register_settings();
        write_reg(CFG_PRESCALER, 32'd3);
        write_reg(CFG_TIMER_CLOCK, 32'd400);
        send_item(REQ_DRIVE, 32'd2, 32'd50);
        repeat (6) send_item(REQ_TICK, 32'd0, 32'd0);
        // shrink the prescaler below the running count
        write_reg(CFG_PRESCALER, 32'd0);
        repeat (4) send_item(REQ_TICK, 32'd0, 32'd0);
        write_reg(CFG_TIMER_CLOCK, 32'd1);
        write_reg(CFG_PRESCALER, 32'd65535);
        send_item(REQ_DRIVE, 32'd1, 32'd1);
        repeat (3) send_item(REQ_TICK, 32'd0, 32'd0);
        write_reg(CFG_UNMAPPED_LO, 32'd12345);
        write_reg(CFG_UNMAPPED_HI, 32'hFFFF_FFFF);
        repeat (2) send_item(REQ_TICK, 32'd0, 32'd0);
        write_reg(CFG_TIMER_CLOCK, 32'hFFFF_FFFF);
        write_reg(CFG_PRESCALER, 32'd0);
        send_item(REQ_DRIVE, -32'sd2, 32'hFFFF_FFFF);
        repeat (3) send_item(REQ_TICK, 32'd0, 32'd0);
        write_reg(CFG_TIMER_CLOCK, 32'd16_000_000);
    endtask

    // Hold the output for a long stretch while requests keep coming.
    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(REQ_DRIVE, 32'd20, 32'd8_000_000);
        hold_left = 300;
        repeat (40) send_item(REQ_TICK, 32'd0, 32'd0);
    endtask

    // Mostly ticks, with drive commands, stops and unused codes mixed in.
    task automatic test_random(input int sender_idle, input int receiver_stall, input int n_items,
                               input logic [31:0] clock_hz, input logic [PSC_W-1:0] psc);
        logic [31:0] tick_rate;
        logic [31:0] count;
        logic [31:0] rate;
        int          pick;
        write_reg(CFG_TIMER_CLOCK, clock_hz);
        write_reg(CFG_PRESCALER, {16'd0, psc});
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        tick_rate = clock_hz / ({16'd0, psc} + 32'd1);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                case ($urandom_range(9))
                    0:       count = $urandom;
                    1:       count = 32'd0;
                    default: begin
                        count = $urandom_range(12, 1);
                        if ($urandom_range(1)) count = 32'd0 - count;
                    end
                endcase
                case ($urandom_range(9))
                    0:       rate = $urandom;
                    1:       rate = 32'd0;
                    default: rate = tick_rate / $urandom_range(6, 1);
                endcase
                send_item(REQ_DRIVE, count, rate);
            end else if (pick < 14) begin
                send_item(REQ_STOP, $urandom, $urandom);
            end else if (pick < 17) begin
                send_item(REQ_UNUSED, $urandom, $urandom);
            end else begin
                send_item(REQ_TICK, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        int drain;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_TICK;
        i_step_count   = '0;
        i_step_rate_hz = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_TIMER_CLOCK;
        i_cfg_data     = '0;

        seq_clock_hz     = TIMER_CLOCK_RESET;
        seq_prescaler    = '0;
        seq_remaining    = '0;
        seq_backward     = 1'b0;
        seq_phase        = 0;
        seq_active       = 1'b0;
        seq_reload       = '0;
        seq_prescale_cnt = '0;
        seq_period_cnt   = '0;
        seq_coils        = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_requests();
        test_forward_run();
        test_backward_run();
        test_extreme_counts();
        test_register_settings();
        test_output_hold();
        test_random(0, 0, 260, 32'd16_000_000, 16'd0);
        test_random(62, 0, 260, 32'd1200, 16'd2);
        test_random(0, 62, 260, 32'hFFFF_FFFF, 16'd1);
        test_random(26, 26, 260, 32'd60, 16'd0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        drain = 0;
        while (expected_coil_states.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (100) @(posedge i_clk);
        while (expected_coil_states.size() != 0) begin
            report_mismatch("result never arrived", expected_coil_states[0].steps_left, 32'd0);
            void'(expected_coil_states.pop_front());
        end
        if (mismatch_count == 0)
            $display("stepper_full_step_sequencer: match");
        else
            $display("stepper_full_step_sequencer: mismatch");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("stepper_full_step_sequencer: mismatch");
        $finish;
    end

endmodule

### stepper_full_step_sequencer.f
sv/ssq_pkg.sv
sv/ssq_div.sv
sv/ssq_dp.sv
sv/ssq_ctrl.sv
sv/stepper_full_step_sequencer.sv
tb/stepper_full_step_sequencer_test.sv
